FILE: sv/lz_ring_decompressor_unit_macros.svh
// Assertion macros used by the checker file of the LZ ring decompressor.
`ifndef LZ_RING_DECOMPRESSOR_UNIT_MACROS_SVH
`define LZ_RING_DECOMPRESSOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LZRD_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lzrd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LZRD_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lzrd assertion failed");

`endif

FILE: sv/lzrd_pkg.sv
// Package with the types and constants of the LZ ring decompressor.
package lzrd_pkg;

	localparam int RING_DEPTH = 1024;
	localparam int RING_AW = $clog2(RING_DEPTH);
	localparam logic [RING_AW-1:0] START_POS = RING_AW'(990);
	localparam int CNT_W = 6;
	localparam int Q_DEPTH = 4;
	localparam int Q_AW = $clog2(Q_DEPTH);

	localparam logic [1:0] KIND_LIT = 2'd0;
	localparam logic [1:0] KIND_ABS = 2'd1;
	localparam logic [1:0] KIND_REL = 2'd2;
	localparam logic [1:0] KIND_NOP = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [RING_AW-1:0] arg;
		logic [CNT_W-1:0] cnt;
		logic clr;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_req_t;

	typedef struct packed {
		logic [7:0] data;
		logic last;
	} res_t;

	typedef struct packed {
		logic valid;
		res_t res;
	} res_req_t;

endpackage

FILE: sv/lzrd_cmdq.sv
// Short command queue between the parser and the ring engine.
module lzrd_cmdq (
	input logic clk,
	input logic arst_n,
	input lzrd_pkg::cmd_req_t wr,
	input logic rd,
	output logic full,
	output logic empty,
	output lzrd_pkg::cmd_t head
);
	import lzrd_pkg::*;

	cmd_t q_mem [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0] cnt_q;

	assign full = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign head = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr.valid) begin
			q_mem[wr_ptr_q] <= wr.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr.valid && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!wr.valid && rd) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/lzrd_resq.sv
// Result queue that holds decompressed bytes until they are taken.
module lzrd_resq (
	input logic clk,
	input logic arst_n,
	input lzrd_pkg::res_req_t wr,
	input logic rd,
	output logic full,
	output logic empty,
	output lzrd_pkg::res_t head
);
	import lzrd_pkg::*;

	res_t q_mem [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0] cnt_q;

	assign full = (cnt_q == (Q_AW+1)'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign head = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr.valid) begin
			q_mem[wr_ptr_q] <= wr.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr.valid && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!wr.valid && rd) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: sv/lzrd_front.sv
// Stream parser that turns compressed bytes into ring commands.
module lzrd_front (
	input logic clk,
	input logic arst_n,
	input logic [7:0] data_byte,
	input logic last_byte,
	input logic take,
	output lzrd_pkg::cmd_req_t req
);
	import lzrd_pkg::*;

	localparam logic [1:0] PH_FLAG = 2'd0;
	localparam logic [1:0] PH_TOKEN = 2'd1;
	localparam logic [1:0] PH_INDEX = 2'd2;
	localparam logic [1:0] PH_RUN = 2'd3;

	logic [1:0] phase_q, phase_n;
	logic [7:0] flags_q, flags_n;
	logic [3:0] tokens_q, tokens_n;
	logic [6:0] run_q, run_n;
	logic [7:0] fcb_q, fcb_n;
	logic has_out;
	logic done;

	always_comb begin
		phase_n = phase_q;
		flags_n = flags_q;
		tokens_n = tokens_q;
		run_n = run_q;
		fcb_n = fcb_q;
		has_out = 1'b0;
		done = 1'b0;
		req.valid = 1'b0;
		req.cmd.kind = KIND_LIT;
		req.cmd.arg = {2'b00, data_byte};
		req.cmd.cnt = CNT_W'(1);
		req.cmd.clr = last_byte;
		unique case (phase_q)
			PH_TOKEN: begin
				if (!flags_q[0]) begin
					has_out = 1'b1;
					done = 1'b1;
				end else if (!data_byte[7]) begin
					fcb_n = data_byte;
					phase_n = PH_INDEX;
				end else if (!data_byte[6]) begin
					has_out = 1'b1;
					req.cmd.kind = KIND_REL;
					req.cmd.arg = {6'b000000, data_byte[3:0]};
					req.cmd.cnt = {4'b0000, data_byte[5:4]} + CNT_W'(2);
					done = 1'b1;
				end else begin
					run_n = {1'b0, data_byte[5:0]} + 7'd8;
					phase_n = PH_RUN;
				end
			end
			PH_INDEX: begin
				has_out = 1'b1;
				req.cmd.kind = KIND_ABS;
				req.cmd.arg = {fcb_q[1:0], data_byte};
				req.cmd.cnt = {1'b0, fcb_q[6:2]} + CNT_W'(3);
				done = 1'b1;
			end
			PH_RUN: begin
				has_out = 1'b1;
				run_n = run_q - 7'd1;
				done = (run_q == 7'd1);
			end
			default: begin
				flags_n = data_byte;
				tokens_n = 4'd8;
				phase_n = PH_TOKEN;
			end
		endcase
		if (done) begin
			flags_n = flags_q >> 1;
			tokens_n = tokens_q - 4'd1;
			phase_n = (tokens_q == 4'd1) ? PH_FLAG : PH_TOKEN;
		end
		if (!has_out) begin
			req.cmd.kind = KIND_NOP;
		end
		req.valid = take && (has_out || last_byte);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FLAG;
			flags_q <= '0;
			tokens_q <= '0;
			run_q <= '0;
			fcb_q <= '0;
		end else if (take) begin
			if (last_byte) begin
				phase_q <= PH_FLAG;
				flags_q <= '0;
				tokens_q <= '0;
				run_q <= '0;
				fcb_q <= '0;
			end else begin
				phase_q <= phase_n;
				flags_q <= flags_n;
				tokens_q <= tokens_n;
				run_q <= run_n;
				fcb_q <= fcb_n;
			end
		end
	end

endmodule

FILE: sv/lzrd_back.sv
// Ring engine that executes commands against the history ring and emits bytes.
module lzrd_back (
	input logic clk,
	input logic arst_n,
	input logic cmd_empty,
	input lzrd_pkg::cmd_t cmd,
	output logic cmd_pop,
	input logic res_full,
	output lzrd_pkg::res_req_t res,
	output logic clearing
);
	import lzrd_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_LIT = 2'd2;
	localparam logic [1:0] ST_COPY = 2'd3;

	logic [7:0] ring_mem [RING_DEPTH];
	logic [1:0] st_q;
	logic [RING_AW-1:0] wp_q;
	logic [RING_AW-1:0] src_q;
	logic [RING_AW-1:0] clr_cnt_q;
	logic [CNT_W-1:0] rem_q;
	logic [7:0] lit_q;
	logic [7:0] rd_q;
	logic clr_after_q;

	logic wr_en;
	logic [RING_AW-1:0] wr_addr;
	logic [7:0] wr_data;
	logic rd_en;
	logic [RING_AW-1:0] rd_addr;
	logic [RING_AW-1:0] start_src;
	logic is_copy;

	assign clearing = (st_q == ST_CLEAR);
	assign is_copy = (cmd.kind == KIND_ABS) || (cmd.kind == KIND_REL);
	assign start_src = (cmd.kind == KIND_ABS) ? cmd.arg : (wp_q - cmd.arg);

	always_comb begin
		wr_en = 1'b0;
		wr_addr = wp_q;
		wr_data = lit_q;
		rd_en = 1'b0;
		rd_addr = src_q;
		cmd_pop = 1'b0;
		res.valid = 1'b0;
		res.res.data = lit_q;
		res.res.last = 1'b1;
		unique case (st_q)
			ST_CLEAR: begin
				wr_en = 1'b1;
				wr_addr = clr_cnt_q;
				wr_data = '0;
			end
			ST_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					if (is_copy) begin
						rd_en = 1'b1;
						rd_addr = start_src;
					end
				end
			end
			ST_LIT: begin
				if (!res_full) begin
					wr_en = 1'b1;
					res.valid = 1'b1;
				end
			end
			default: begin
				res.res.data = rd_q;
				res.res.last = (rem_q == CNT_W'(1));
				wr_data = rd_q;
				if (!res_full) begin
					wr_en = 1'b1;
					res.valid = 1'b1;
					rd_en = (rem_q != CNT_W'(1));
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= (wr_en && (wr_addr == rd_addr)) ? wr_data : ring_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			wp_q <= START_POS;
			src_q <= '0;
			clr_cnt_q <= '0;
			rem_q <= '0;
			lit_q <= '0;
			clr_after_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == RING_AW'(RING_DEPTH - 1)) begin
						st_q <= ST_IDLE;
						wp_q <= START_POS;
					end
				end
				ST_IDLE: begin
					if (!cmd_empty) begin
						clr_after_q <= cmd.clr;
						lit_q <= cmd.arg[7:0];
						rem_q <= cmd.cnt;
						src_q <= start_src + 1'b1;
						if (cmd.kind == KIND_LIT) begin
							st_q <= ST_LIT;
						end else if (is_copy) begin
							st_q <= ST_COPY;
						end else begin
							st_q <= cmd.clr ? ST_CLEAR : ST_IDLE;
						end
					end
				end
				ST_LIT: begin
					if (!res_full) begin
						wp_q <= wp_q + 1'b1;
						st_q <= clr_after_q ? ST_CLEAR : ST_IDLE;
					end
				end
				default: begin
					if (!res_full) begin
						wp_q <= wp_q + 1'b1;
						rem_q <= rem_q - 1'b1;
						if (rem_q == CNT_W'(1)) begin
							st_q <= clr_after_q ? ST_CLEAR : ST_IDLE;
						end else begin
							src_q <= src_q + 1'b1;
						end
					end
				end
			endcase
		end
	end

endmodule

FILE: sv/lz_ring_decompressor_unit.sv
// Top level of the LZ ring decompressor with a 1024-byte history window.
//
// Compressed bytes enter through a queue-style port: an item is taken at a
// clock edge with push high and full low; last_byte marks the end of a stream.
// Decompressed bytes leave through a second queue-style port: while empty is
// low the oldest byte is on out_byte, and pop takes it. last_of_run is set on
// the final byte that one input item produces.
// A parser accepts one item per cycle while full is low and hands commands to
// a four-entry queue; a ring engine executes them from a history memory with
// one read and one write port. The engine pops each command in its idle state
// and then writes the literal, or each byte of a copy, into the ring and the
// result queue; its one write per cycle into the ring bounds the output rate at
// one byte per cycle.
// After reset, and after every item marked last, the engine sweeps all 1024
// ring entries to zero, one entry a cycle; full stays high during that sweep.
// When the receiver stops popping, the result queue fills, the engine holds
// its current byte, and the command queue then raises full.
module lz_ring_decompressor_unit (
	input logic clk,
	input logic arst_n,
	input logic [7:0] data_byte,
	input logic last_byte,
	input logic push,
	output logic full,
	output logic [7:0] out_byte,
	output logic last_of_run,
	output logic empty,
	input logic pop
);
	import lzrd_pkg::*;

	cmd_req_t cmd_req;
	cmd_t cmd_head;
	res_req_t res_req;
	res_t res_head;
	logic cq_full;
	logic cq_empty;
	logic cmd_pop;
	logic rq_full;
	logic bk_clearing;
	logic take;

	assign full = cq_full || bk_clearing;
	assign take = push && !full;
	assign out_byte = res_head.data;
	assign last_of_run = res_head.last;

	lzrd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.take(take),
		.req(cmd_req)
	);

	lzrd_cmdq u_cmdq (
		.clk(clk),
		.arst_n(arst_n),
		.wr(cmd_req),
		.rd(cmd_pop),
		.full(cq_full),
		.empty(cq_empty),
		.head(cmd_head)
	);

	lzrd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_empty(cq_empty),
		.cmd(cmd_head),
		.cmd_pop(cmd_pop),
		.res_full(rq_full),
		.res(res_req),
		.clearing(bk_clearing)
	);

	lzrd_resq u_resq (
		.clk(clk),
		.arst_n(arst_n),
		.wr(res_req),
		.rd(pop && !empty),
		.full(rq_full),
		.empty(empty),
		.head(res_head)
	);

endmodule

FILE: sv/lzrd_checker.sv
// Port checker for the LZ ring decompressor and its bind to the top level.
`include "lz_ring_decompressor_unit_macros.svh"

module lzrd_checker (
	input logic clk,
	input logic arst_n,
	input logic full,
	input logic empty,
	input logic pop,
	input logic [7:0] out_byte,
	input logic last_of_run
);

	// A waiting item that is not taken stays on the result ports unchanged.
	`LZRD_ASSERT_NEXT(a_res_hold, clk, arst_n, !empty && !pop, !empty && $stable(out_byte) && $stable(last_of_run))

	// Right after reset the ring sweep is running, so no item is taken.
	`LZRD_ASSERT_IMPL(a_full_after_reset, clk, arst_n, $past(!arst_n), full)

	// Right after reset no result is waiting.
	`LZRD_ASSERT_IMPL(a_empty_after_reset, clk, arst_n, $past(!arst_n), empty)

endmodule

bind lz_ring_decompressor_unit lzrd_checker u_lzrd_checker (.*);

FILE: test/tb_lz_ring_decompressor_unit.sv
// Self-checking testbench of lz_ring_decompressor_unit: compressed streams in, byte-exact check out.
`timescale 1ns / 1ps

module tb_lz_ring_decompressor_unit;
	import lzrd_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 50;

	typedef struct packed {
		logic [7:0] data;
		logic last;
	} comp_item_t;

	// Tracks the decoder state and queues the bytes each compressed item must produce.
	class decomp_scoreboard;
		typedef enum logic [1:0] {PARSE_FLAG, PARSE_TOKEN, PARSE_INDEX, PARSE_RUN} parse_e;

		logic [7:0] history [RING_DEPTH];
		logic [RING_AW-1:0] wr_pos;
		logic [7:0] flags;
		logic [3:0] tokens_left;
		parse_e phase;
		logic [6:0] run_left;
		logic [7:0] held_cmd;
		res_t pending_bytes[$];
		int mismatches;
		int bytes_checked;
		int bytes_in;
		int streams;
		int most_per_byte;

		function new();
			mismatches = 0;
			bytes_checked = 0;
			bytes_in = 0;
			streams = 0;
			most_per_byte = 0;
			clear_state();
		endfunction

		function void clear_state();
			foreach (history[i]) history[i] = 8'h00;
			wr_pos = START_POS;
			flags = 8'h00;
			tokens_left = 4'd0;
			phase = PARSE_FLAG;
			run_left = 7'd0;
			held_cmd = 8'h00;
		endfunction

		function void emit(logic [7:0] v);
			res_t r;
			r.data = v;
			r.last = 1'b0;
			pending_bytes.push_back(r);
			history[wr_pos] = v;
			wr_pos = wr_pos + 1'b1;
		endfunction

		function void token_done();
			flags = flags >> 1;
			tokens_left = tokens_left - 1'b1;
			phase = (tokens_left == 4'd0) ? PARSE_FLAG : PARSE_TOKEN;
		endfunction

		function void take_byte(logic [7:0] d, logic lst);
			int n_before;
			int cnt;
			logic [RING_AW-1:0] src;
			n_before = pending_bytes.size();
			bytes_in++;
			case (phase)
				PARSE_TOKEN: begin
					if (!flags[0]) begin
						emit(d);
						token_done();
					end else if (d < 8'h80) begin
						held_cmd = d;
						phase = PARSE_INDEX;
					end else if (d < 8'hC0) begin
						cnt = int'(d[5:4]) + 2;
						for (int i = 0; i < cnt; i++)
							emit(history[wr_pos - RING_AW'(d[3:0])]);
						token_done();
					end else begin
						run_left = 7'(d[5:0]) + 7'd8;
						phase = PARSE_RUN;
					end
				end
				PARSE_INDEX: begin
					src = {held_cmd[1:0], d};
					cnt = int'(held_cmd[7:2]) + 3;
					for (int i = 0; i < cnt; i++) begin
						emit(history[src]);
						src = src + 1'b1;
					end
					token_done();
				end
				PARSE_RUN: begin
					emit(d);
					run_left = run_left - 1'b1;
					if (run_left == 7'd0)
						token_done();
				end
				default: begin
					flags = d;
					tokens_left = 4'd8;
					phase = PARSE_TOKEN;
				end
			endcase
			if (pending_bytes.size() > n_before)
				pending_bytes[pending_bytes.size() - 1].last = 1'b1;
			if (pending_bytes.size() - n_before > most_per_byte)
				most_per_byte = pending_bytes.size() - n_before;
			if (lst) begin
				clear_state();
				streams++;
			end
		endfunction

		function void check_byte(logic [7:0] d, logic lst);
			res_t want;
			if (pending_bytes.size() == 0) begin
				$display("%0t: unexpected output byte %h last_of_run %b", $time, d, lst);
				mismatches++;
				return;
			end
			want = pending_bytes.pop_front();
			bytes_checked++;
			if (want.data !== d) begin
				$display("%0t: out_byte expected %h actual %h", $time, want.data, d);
				mismatches++;
			end
			if (want.last !== lst) begin
				$display("%0t: last_of_run expected %b actual %b", $time, want.last, lst);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic [7:0] data_byte = 8'h00;
	logic last_byte = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [7:0] out_byte;
	logic last_of_run;
	logic empty;
	logic pop = 1'b0;

	bit hold_req = 1'b0;
	bit calm = 1'b0;
	int input_stalls = 0;
	comp_item_t stream_bytes[$];
	decomp_scoreboard sb;

	lz_ring_decompressor_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.push(push),
		.full(full),
		.out_byte(out_byte),
		.last_of_run(last_of_run),
		.empty(empty),
		.pop(pop)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				sb.check_byte(out_byte, last_of_run);
			if (push && !full)
				sb.take_byte(data_byte, last_byte);
			if (push && full)
				input_stalls++;
		end
	end

	function automatic void add(logic [7:0] d, logic lst = 1'b0);
		comp_item_t it;
		it.data = d;
		it.last = lst;
		stream_bytes.push_back(it);
	endfunction

	function automatic void end_stream();
		stream_bytes[stream_bytes.size() - 1].last = 1'b1;
	endfunction

	// Kind 1 gives only absolute copies of the two longest lengths, kind 2 only zero-distance relative copies.
	function automatic void gen_token(logic is_cmd, int kind);
		int pick;
		int code;
		if (!is_cmd) begin
			add(8'($urandom));
			return;
		end
		pick = (kind == 1) ? 0 : (kind == 2) ? 50 : $urandom_range(0, 99);
		if (pick < 40) begin
			if (kind == 1)
				add(8'(($urandom_range(30, 31) << 2) | $urandom_range(0, 3)));
			else
				add(8'($urandom_range(0, 127)));
			add(8'($urandom));
		end else if (pick < 75) begin
			add(8'(8'h80 | ($urandom_range(0, 3) << 4) |
				((kind == 2) ? 0 : $urandom_range(0, 15))));
		end else begin
			code = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 4);
			add(8'(8'hC0 | code));
			repeat (code + 8) add(8'($urandom));
		end
	endfunction

	function automatic void gen_block(int kind, int ntok);
		logic [7:0] flag;
		flag = (kind == 1) ? 8'hFF : 8'($urandom);
		if (kind == 2)
			flag = flag | 8'h0F;
		add(flag);
		for (int t = 0; t < ntok; t++)
			gen_token(flag[t], kind);
	endfunction

	function automatic void cut_stream();
		int how;
		int code;
		how = $urandom_range(0, 2);
		if (how == 0) begin
			add(8'($urandom), 1'b1);
		end else if (how == 1) begin
			add(8'($urandom) | 8'h01);
			add(8'($urandom_range(0, 127)), 1'b1);
		end else begin
			code = $urandom_range(0, 63);
			add(8'($urandom) | 8'h01);
			add(8'(8'hC0 | code));
			repeat ($urandom_range(1, code + 7)) add(8'($urandom));
			end_stream();
		end
	endfunction

	initial begin
		int idle;
		idle = 0;
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				idle = 0;
			else
				idle++;
		end
		$display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			pop <= 1'b1;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	end

	initial begin
		int pause_at;
		int hold_at;
		int calm_at;
		sb = new();

		// Literal extremes, shortest and longest absolute copy (overlapping), relative copies.
		add(8'hF0);
		add(8'h00);
		add(8'hFF);
		add(8'hA5);
		add(8'h5A);
		add(8'h03);
		add(8'hDE);
		add(8'h7F);
		add(8'hE0);
		add(8'h81);
		add(8'hBF, 1'b1);
		// Zero distance, then a literal run cut short by the end of the stream.
		add(8'h07);
		add(8'h80);
		add(8'hC0);
		add(8'h3C);
		add(8'hC3);
		add(8'h96, 1'b1);
		// Absolute copy left pending, then a stream that is only a flag byte.
		add(8'hFF);
		add(8'h7C, 1'b1);
		add(8'h00, 1'b1);

		pause_at = stream_bytes.size();
		gen_block(0, 8);
		hold_at = stream_bytes.size();
		repeat (4) gen_block(1, 8);
		gen_block(2, 8);
		gen_block(0, 8);
		end_stream();

		while (stream_bytes.size() < 160) begin
			case ($urandom_range(0, 9))
				7: cut_stream();
				8, 9: begin
					repeat ($urandom_range(3, 8))
						add(8'($urandom), $urandom_range(0, 15) == 0);
					end_stream();
				end
				default: begin
					repeat ($urandom_range(0, 2)) gen_block(0, 8);
					gen_block(0, $urandom_range(1, 8));
					end_stream();
				end
			endcase
		end
		calm_at = stream_bytes.size();
		gen_block(0, 8);
		end_stream();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < stream_bytes.size(); i++) begin
			if (i == pause_at) begin
				push <= 1'b0;
				do @(posedge clk); while (sb.pending_bytes.size() != 0);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			if (i == hold_at)
				hold_req = 1'b1;
			if (i == calm_at)
				calm = 1'b1;
			data_byte <= stream_bytes[i].data;
			last_byte <= stream_bytes[i].last;
			push <= 1'b1;
			do @(posedge clk); while (full);
		end
		push <= 1'b0;
		@(posedge clk);

		while (sb.pending_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Decoded %0d streams from %0d compressed bytes into %0d checked bytes.",
			sb.streams, sb.bytes_in, sb.bytes_checked);
		$display("Up to %0d bytes from one input; input held back for %0d cycles.",
			sb.most_per_byte, input_stalls);
		if (sb.mismatches == 0 && sb.pending_bytes.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
